// ===== rtl/sida_pkg.sv =====
// Shared types, character codes and the control program of the decimal text converter.
package sida_pkg;

  // Width of the step counter of the control program.
  localparam int unsigned PC_W = 2;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_SHIFT,
    OP_SIGN,
    OP_DIGIT
  } op_t;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_CNT_LEFT,
    COND_DIGIT_LEFT
  } cond_t;

  // When a step completes it jumps to target if its condition holds, else falls through.
  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  localparam logic [PC_W-1:0] PC_LOAD  = PC_W'(0);
  localparam logic [PC_W-1:0] PC_SHIFT = PC_W'(1);
  localparam logic [PC_W-1:0] PC_SIGN  = PC_W'(2);
  localparam logic [PC_W-1:0] PC_DIGIT = PC_W'(3);

  function automatic ctrl_word_t rom_word(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    case (pc)
      PC_LOAD:  w = '{op: OP_LOAD,  cond: COND_ALWAYS,     target: PC_SHIFT};
      PC_SHIFT: w = '{op: OP_SHIFT, cond: COND_CNT_LEFT,   target: PC_SHIFT};
      PC_SIGN:  w = '{op: OP_SIGN,  cond: COND_ALWAYS,     target: PC_DIGIT};
      PC_DIGIT: w = '{op: OP_DIGIT, cond: COND_DIGIT_LEFT, target: PC_DIGIT};
      default:  w = '{op: OP_LOAD,  cond: COND_ALWAYS,     target: PC_LOAD};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/sida_value_if.sv =====
// Request channel that carries one signed integer to be converted.
interface sida_value_if #(parameter int VALUE_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// ===== rtl/sida_text_if.sv =====
// Request channel that carries one ASCII character of the decimal text.
interface sida_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       final_char;

  modport source (output valid, output text_char, output final_char, input ready);
  modport sink (input valid, input text_char, input final_char, output ready);
endinterface

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// Signed integer to decimal ASCII converter, run by a small microcoded sequencer.
//
// Usage: one request on the number channel carries a signed two's complement
// value of VALUE_WIDTH bits. The block answers with its decimal text on the
// text channel, one character per request, most significant first: a leading
// '-' for a negative value, no leading zeros, "0" for zero. final_char marks
// the last character of each number.
// Sequence: a four-step program in a constant table drives the datapath. The
// first step takes the value, VALUE_WIDTH rounds of shift-and-add-3 convert
// the magnitude to BCD, one step handles the sign and one step goes to each
// BCD digit position, (VALUE_WIDTH*3)/10+1 of them; the BCD shift loop is the
// longest part of the work.
// The number channel is ready only while the program waits at its first step,
// so one item is worked on at a time; it is ready again while the last
// character still sits in the output register.
// Stalls: a held text request freezes the program at the sign or digit step that loads a character.
// Reset returns the program to its first step and drops the output request.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  sida_value_if.sink          number,
  sida_text_if.source         text
);

  localparam int NDIG  = (VALUE_WIDTH * 3) / 10 + 1;
  localparam int CNT_W = $clog2(VALUE_WIDTH);
  localparam int IDX_W = $clog2(NDIG);

  typedef logic [NDIG-1:0][3:0] bcd_t;

  logic [sida_pkg::PC_W-1:0] pc, pc_next;
  sida_pkg::ctrl_word_t      cw;
  logic [VALUE_WIDTH-1:0]    mag, mag_next;
  bcd_t                      bcd, bcd_next, bcd_adj;
  logic [CNT_W-1:0]          cnt, cnt_next;
  logic [IDX_W-1:0]          idx, idx_next;
  logic                      neg, neg_next;
  logic                      started, started_next;
  logic                      out_valid, out_valid_next;
  logic [7:0]                out_char, out_char_next;
  logic                      out_final, out_final_next;

  logic                      slot_free;
  logic                      step_go;
  logic                      cond_true;
  logic                      out_load;
  logic [3:0]                digit;
  logic                      emit_digit;

  assign cw        = sida_pkg::rom_word(pc);
  assign slot_free = !out_valid || text.ready;
  assign digit     = bcd[idx];
  assign emit_digit = started || (digit != 4'd0) || (idx == '0);

  assign number.ready    = (cw.op == sida_pkg::OP_LOAD);
  assign text.valid      = out_valid;
  assign text.text_char  = out_char;
  assign text.final_char = out_final;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
  end

  always_comb begin
    case (cw.cond)
      sida_pkg::COND_ALWAYS:     cond_true = 1'b1;
      sida_pkg::COND_CNT_LEFT:   cond_true = (cnt != '0);
      sida_pkg::COND_DIGIT_LEFT: cond_true = (idx != '0);
      default:                   cond_true = 1'b0;
    endcase
  end

  always_comb begin
    pc_next        = pc;
    mag_next       = mag;
    bcd_next       = bcd;
    cnt_next       = cnt;
    idx_next       = idx;
    neg_next       = neg;
    started_next   = started;
    out_char_next  = out_char;
    out_final_next = out_final;
    out_load       = 1'b0;
    step_go        = 1'b0;

    case (cw.op)
      sida_pkg::OP_LOAD: begin
        step_go = number.valid;
        if (number.valid) begin
          neg_next     = number.value[VALUE_WIDTH-1];
          // The most negative value negates to itself, which read unsigned is its magnitude.
          mag_next     = number.value[VALUE_WIDTH-1] ? -number.value : number.value;
          bcd_next     = '0;
          cnt_next     = CNT_W'(VALUE_WIDTH - 1);
          idx_next     = IDX_W'(NDIG - 1);
          started_next = 1'b0;
        end
      end
      sida_pkg::OP_SHIFT: begin
        step_go  = 1'b1;
        bcd_next = bcd_t'({bcd_adj, mag[VALUE_WIDTH-1]});
        mag_next = {mag[VALUE_WIDTH-2:0], 1'b0};
        cnt_next = cnt - 1'b1;
      end
      sida_pkg::OP_SIGN: begin
        step_go = !neg || slot_free;
        if (neg && slot_free) begin
          out_load       = 1'b1;
          out_char_next  = sida_pkg::CHAR_MINUS;
          out_final_next = 1'b0;
        end
      end
      sida_pkg::OP_DIGIT: begin
        // Leading zeros are skipped without waiting for the output register.
        step_go = !emit_digit || slot_free;
        if (step_go) begin
          idx_next = idx - 1'b1;
        end
        if (emit_digit && slot_free) begin
          out_load       = 1'b1;
          started_next   = 1'b1;
          out_char_next  = sida_pkg::CHAR_ZERO + {4'd0, digit};
          out_final_next = (idx == '0);
        end
      end
      default: begin
        step_go = 1'b1;
      end
    endcase

    if (step_go) begin
      pc_next = cond_true ? cw.target : pc + 1'b1;
    end

    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (text.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= sida_pkg::PC_LOAD;
      out_valid <= 1'b0;
      started   <= 1'b0;
    end else begin
      pc        <= pc_next;
      out_valid <= out_valid_next;
      started   <= started_next;
    end
    mag       <= mag_next;
    bcd       <= bcd_next;
    cnt       <= cnt_next;
    idx       <= idx_next;
    neg       <= neg_next;
    out_char  <= out_char_next;
    out_final <= out_final_next;
  end

  // An accepted value always starts the BCD conversion.
  a_load_to_shift: assert property (@(posedge clk) disable iff (rst)
    number.valid && number.ready |=> pc == sida_pkg::PC_SHIFT)
    else $error("accepted value did not start the conversion");

  // The shift loop ends exactly when its counter runs out.
  a_shift_exit: assert property (@(posedge clk) disable iff (rst)
    pc == sida_pkg::PC_SHIFT && cnt == '0 |=> pc == sida_pkg::PC_SIGN)
    else $error("shift loop did not end on its last shift");

  // Loading the last character returns the program to its first step.
  a_final_returns: assert property (@(posedge clk) disable iff (rst)
    out_load && out_final_next |=> pc == sida_pkg::PC_LOAD)
    else $error("program did not return after the last character");

  // Every character shown is a minus sign or a decimal digit.
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    text.valid |-> text.text_char == sida_pkg::CHAR_MINUS ||
                   (text.text_char >= sida_pkg::CHAR_ZERO &&
                    text.text_char <= sida_pkg::CHAR_NINE))
    else $error("character out of range");

  // A minus sign is never the last character.
  a_minus_not_final: assert property (@(posedge clk) disable iff (rst)
    text.valid && text.text_char == sida_pkg::CHAR_MINUS |-> !text.final_char)
    else $error("minus sign flagged as last character");

endmodule

// ===== dv/signed_int_to_decimal_ascii_tb.sv =====
// Self-checking testbench for the signed integer to decimal ASCII converter.
module signed_int_to_decimal_ascii_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_WIDTH = 32;
  localparam int N_RANDOM    = 100;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 60;

  typedef struct {
    logic [VALUE_WIDTH-1:0] value;
    string                  text;
  } num_row_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_exp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sida_value_if #(.VALUE_WIDTH(VALUE_WIDTH)) number_if ();
  sida_text_if text_if ();

  signed_int_to_decimal_ascii #(.VALUE_WIDTH(VALUE_WIDTH)) u_dut (
    .clk   (clk),
    .rst   (rst),
    .number(number_if),
    .text  (text_if)
  );

  always #5 clk = ~clk;

  text_exp_t expected_text[$];
  num_row_t  dir_rows[22];
  int        err_cnt      = 0;
  int        char_cnt     = 0;
  int        num_cnt      = 0;
  int        neg_cnt      = 0;
  int        hold_cnt_tot = 0;
  int        cycle_cnt    = 0;
  int        hold_seq     = 0;

  // Works out the characters of one accepted number and queues them.
  function automatic void predict_text(input logic [VALUE_WIDTH-1:0] v);
    logic [VALUE_WIDTH-1:0] mag;
    logic [7:0]             digs[$];
    logic                   neg;
    neg = v[VALUE_WIDTH-1];
    // The most negative value wraps back onto itself, read as unsigned it is right.
    mag = neg ? (~v + 1'b1) : v;
    do begin
      digs.push_front(sida_pkg::CHAR_ZERO + 8'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (neg) expected_text.push_back('{ch: sida_pkg::CHAR_MINUS, last: 1'b0});
    foreach (digs[i]) expected_text.push_back('{ch: digs[i], last: (i == digs.size() - 1)});
  endfunction

  function automatic void queue_typed_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      expected_text.push_back('{ch: s[i], last: (i == s.len() - 1)});
    end
  endfunction

  // Offers one number and waits for its request to be taken; a nonzero gap then withdraws the request and idles.
  task automatic offer_number(input logic [VALUE_WIDTH-1:0] v, input string typed, input int gap);
    number_if.valid <= 1'b1;
    number_if.value <= v;
    do @(posedge clk); while (!(number_if.valid && number_if.ready));
    if (typed.len() != 0) queue_typed_text(typed);
    else predict_text(v);
    num_cnt++;
    if (v[VALUE_WIDTH-1]) neg_cnt++;
    if (gap > 0) begin
      number_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (expected_text.size() != 0) @(posedge clk);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    longint p;
    longint m;
    int     r;
    r = $urandom_range(0, 99);
    p = 1;
    repeat ($urandom_range(0, 9)) p = p * 10;
    if (r < 25) begin
      return $urandom();
    end else if (r < 65) begin
      m = longint'($urandom()) % (p + 1);
    end else if (r < 85) begin
      m = p + $urandom_range(0, 2) - 1;
    end else begin
      m = 64'sd2147483647 - $urandom_range(0, 20);
      // One step further out on the negative side, which reaches the most negative value when m is the top.
      if ($urandom_range(0, 1) == 1) return VALUE_WIDTH'(-(m + 1));
      return VALUE_WIDTH'(m);
    end
    if ($urandom_range(0, 1) == 1) return VALUE_WIDTH'(-m);
    return VALUE_WIDTH'(m);
  endfunction

  // Receiver: random ready with changing density, occasional short hold-offs, plus long hold-offs on demand.
  initial begin
    int hold_left;
    int seen_seq;
    int ready_pct;
    int phase_left;
    hold_left  = 0;
    seen_seq   = 0;
    ready_pct  = 100;
    phase_left = 0;
    text_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (phase_left == 0) begin
        case ($urandom_range(0, 4))
          0, 1: ready_pct = 100;
          2: ready_pct = 75;
          3: ready_pct = 35;
          default: ready_pct = 8;
        endcase
        phase_left = $urandom_range(50, 300);
      end else begin
        phase_left--;
      end
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = HOLD_CYCLES;
        hold_cnt_tot++;
      end else if (hold_left == 0 && $urandom_range(0, 399) == 0) begin
        hold_left = $urandom_range(20, 80);
      end
      if (hold_left > 0) begin
        hold_left--;
        text_if.ready <= 1'b0;
      end else begin
        text_if.ready <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  // Checks every character request against the oldest expectation.
  always @(posedge clk) begin
    text_exp_t e;
    if (!rst && text_if.valid && text_if.ready) begin
      char_cnt++;
      if (expected_text.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected character: expected none, got char=%02h final=%b", $time,
                 text_if.text_char, text_if.final_char);
      end else begin
        e = expected_text.pop_front();
        if (text_if.text_char !== e.ch || text_if.final_char !== e.last) begin
          err_cnt++;
          $display("%0t: mismatch: expected char=%02h final=%b, got char=%02h final=%b",
                   $time, e.ch, e.last, text_if.text_char, text_if.final_char);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d characters still expected", $time, expected_text.size());
      $display("** signed_int_to_decimal_ascii: FAILED **");
      $finish;
    end
  end

  initial begin
    dir_rows = '{
      '{32'd0,            "0"},
      '{32'd1,            "1"},
      '{-32'sd1,          "-1"},
      '{32'h7FFF_FFFF,    "2147483647"},
      '{32'h8000_0000,    "-2147483648"},
      '{-32'sd2147483647, "-2147483647"},
      '{32'd9,            ""},
      '{32'd10,           ""},
      '{-32'sd9,          ""},
      '{-32'sd10,         ""},
      '{32'd99,           ""},
      '{32'd100,          ""},
      '{32'd12345,        ""},
      '{-32'sd54321,      ""},
      '{32'd999999999,    ""},
      '{32'd1000000000,   ""},
      '{-32'sd1000000000, ""},
      '{32'h5555_5555,    ""},
      '{32'hAAAA_AAAA,    ""},
      '{32'h0F0F_0F0F,    ""},
      '{32'd7,            ""},
      '{-32'sd2147483640, ""}
    };
    number_if.valid = 1'b0;
    number_if.value = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) offer_number(dir_rows[i].value, dir_rows[i].text, pick_gap());
    number_if.valid <= 1'b0;
    wait_drained();

    for (int n = 0; n < N_RANDOM; n++) begin
      // Long output hold-offs while numbers keep coming, so the input backs up.
      if (n == 30 || n == 85) hold_seq <= hold_seq + 1;
      offer_number(pick_value(), "", pick_gap());
      if (n % 40 == 39) begin
        number_if.valid <= 1'b0;
        wait_drained();
      end
    end
    number_if.valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_text.size() != 0) err_cnt++;

    $display("Converted %0d numbers (%0d negative, both extremes included) into %0d characters,",
             num_cnt, neg_cnt, char_cnt);
    $display("with %0d long output hold-offs and random idling on both channels.", hold_cnt_tot);
    if (err_cnt == 0) begin
      $display("** signed_int_to_decimal_ascii: PASSED **");
    end else begin
      $display("** signed_int_to_decimal_ascii: FAILED **");
    end
    $finish;
  end

endmodule
